[src/page_bitmap_blit_with_clipping_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the page bitmap blit core
// Concurrent checks, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef PAGE_BITMAP_BLIT_WITH_CLIPPING_CORE_ASSERT_SVH
`define PAGE_BITMAP_BLIT_WITH_CLIPPING_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define PBB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// antecedent implies consequent in the next cycle
`define PBB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PBB_ASSERT_SAME(label, ante, cons, msg)
`define PBB_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[src/pbb_pkg.sv]
// ----------------------------------------------------------------------------
// pbb_pkg
// Shared types and constants of the page bitmap blit core.
// ----------------------------------------------------------------------------
package pbb_pkg;

  localparam int DEF_DISPLAY_COLUMNS = 128;
  localparam int DEF_DISPLAY_PAGES   = 8;

  localparam int BYTE_W  = 8;
  localparam int ADDR_W  = 10;
  localparam int MODE_W  = 2;
  localparam int INDEX_W = 2;
  localparam int SUM_W   = 9;
  localparam int PROD_W  = 18;

  localparam logic [MODE_W-1:0] MODE_FILL   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BITMAP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

  localparam logic [INDEX_W-1:0] REG_DEST_COLUMN  = 2'd0;
  localparam logic [INDEX_W-1:0] REG_DEST_PAGE    = 2'd1;
  localparam logic [INDEX_W-1:0] REG_BITMAP_WIDTH = 2'd2;
  localparam logic [INDEX_W-1:0] REG_BITMAP_PAGES = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] dest_column;
    logic [BYTE_W-1:0] dest_page;
    logic [BYTE_W-1:0] bitmap_width;
    logic [BYTE_W-1:0] bitmap_pages;
  } cfg_t;

  typedef struct packed {
    logic              placed;
    logic [ADDR_W-1:0] write_address;
  } place_t;

endpackage

[src/pbb_frame_mem.sv]
// ----------------------------------------------------------------------------
// pbb_frame_mem
// Frame store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pbb_frame_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/pbb_place.sv]
// ----------------------------------------------------------------------------
// pbb_place
// Source position tracking, clipping and destination address of bitmap items.
// ----------------------------------------------------------------------------
module pbb_place import pbb_pkg::*; #(
  parameter int COLS  = DEF_DISPLAY_COLUMNS,
  parameter int PAGES = DEF_DISPLAY_PAGES,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          advance,
  input  logic          first_byte,
  output place_t        result,
  output logic [AW-1:0] addr
);

  logic [BYTE_W-1:0] src_col;
  logic [BYTE_W-1:0] src_page;
  logic [BYTE_W-1:0] col_eff;
  logic [BYTE_W-1:0] page_eff;
  logic              active;
  logic              origin_ok;
  logic [SUM_W-1:0]  col_sum;
  logic [SUM_W-1:0]  page_sum;
  logic [SUM_W-1:0]  col_inc;
  logic              wrap;
  logic              placed;
  logic [PROD_W-1:0] addr_wide;

  always_comb begin
    col_eff   = first_byte ? '0 : src_col;
    page_eff  = first_byte ? '0 : src_page;
    active    = (cfg.bitmap_width != '0) && (page_eff < cfg.bitmap_pages);
    origin_ok = ({1'b0, cfg.dest_column} < SUM_W'(COLS)) &&
                ({1'b0, cfg.dest_page} < SUM_W'(PAGES));
    col_sum   = {1'b0, cfg.dest_column} + {1'b0, col_eff};
    page_sum  = {1'b0, cfg.dest_page} + {1'b0, page_eff};
    placed    = active && origin_ok && (col_sum < SUM_W'(COLS)) &&
                (page_sum < SUM_W'(PAGES));
    addr_wide = PROD_W'(page_sum) * PROD_W'(COLS) + PROD_W'(col_sum);
    col_inc   = {1'b0, col_eff} + SUM_W'(1);
    wrap      = col_inc >= {1'b0, cfg.bitmap_width};
  end

  assign addr                 = addr_wide[AW-1:0];
  assign result.placed        = placed;
  assign result.write_address = placed ? addr_wide[ADDR_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_col  <= '0;
      src_page <= '0;
    end else if (advance) begin
      if (active) begin
        if (wrap) begin
          src_col  <= '0;
          src_page <= page_eff + BYTE_W'(1);
        end else begin
          src_col  <= col_inc[BYTE_W-1:0];
          src_page <= page_eff;
        end
      end else if (first_byte) begin
        src_col  <= '0;
        src_page <= '0;
      end
    end
  end

endmodule

[src/page_bitmap_blit_with_clipping_core.sv]
// ----------------------------------------------------------------------------
// page_bitmap_blit_with_clipping_core
// Page-organised monochrome frame store with fill, clipped bitmap blit and read.
// ----------------------------------------------------------------------------
// Timing: a bitmap item, a fill command and an unused mode code are taken and
// yield their registered result in the next cycle; a read passes through the
// registered read data of the frame memory and S_READ before its result. A fill
// then sweeps the store through the single write port, one entry a cycle, so the
// block takes no new item until all DISPLAY_COLUMNS * DISPLAY_PAGES entries are
// written. Store contents are undefined after reset until the first fill.
`include "page_bitmap_blit_with_clipping_core_assert.svh"

module page_bitmap_blit_with_clipping_core import pbb_pkg::*; #(
  parameter int DISPLAY_COLUMNS = DEF_DISPLAY_COLUMNS,
  parameter int DISPLAY_PAGES   = DEF_DISPLAY_PAGES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [MODE_W-1:0]  mode,
  input  logic [BYTE_W-1:0]  data_byte,
  input  logic               first_byte,
  input  logic [ADDR_W-1:0]  read_address,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [BYTE_W-1:0]  read_data,
  output logic               byte_written,
  output logic [ADDR_W-1:0]  write_address,
  input  logic               write_enable,
  input  logic [INDEX_W-1:0] register_index,
  input  logic [BYTE_W-1:0]  write_data
);

  localparam int STORE_SIZE = DISPLAY_COLUMNS * DISPLAY_PAGES;
  localparam int AW         = $clog2(STORE_SIZE);
  localparam int RAW        = (AW > ADDR_W) ? AW : ADDR_W;

  typedef enum logic [1:0] {S_IDLE, S_FILL, S_READ} state_t;

  state_t            state;
  cfg_t              cfg;
  logic [AW-1:0]     sweep;
  logic [BYTE_W-1:0] fill_byte;
  logic              rd_ok;
  logic              accept;
  logic              rd_in_range;
  logic [RAW-1:0]    rd_ext;
  place_t            pl;
  logic [AW-1:0]     pl_addr;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic [BYTE_W-1:0] mem_rdata;

  assign in_ready    = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept      = in_valid && in_ready;
  assign rd_ext      = RAW'(read_address);
  assign rd_in_range = 32'(read_address) < 32'(STORE_SIZE);

  pbb_place #(
    .COLS  (DISPLAY_COLUMNS),
    .PAGES (DISPLAY_PAGES),
    .AW    (AW)
  ) u_place (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .advance    (accept && (mode == MODE_BITMAP)),
    .first_byte (first_byte),
    .result     (pl),
    .addr       (pl_addr)
  );

  always_comb begin
    mem_we    = (state == S_FILL) || (accept && (mode == MODE_BITMAP) && pl.placed);
    mem_waddr = (state == S_FILL) ? sweep : pl_addr;
    mem_wdata = (state == S_FILL) ? fill_byte : data_byte;
  end

  pbb_frame_mem #(
    .DEPTH (STORE_SIZE),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_ext[AW-1:0]),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cfg       <= '0;
    end else begin
      if (write_enable) begin
        unique case (register_index)
          REG_DEST_COLUMN:  cfg.dest_column  <= write_data;
          REG_DEST_PAGE:    cfg.dest_page    <= write_data;
          REG_BITMAP_WIDTH: cfg.bitmap_width <= write_data;
          REG_BITMAP_PAGES: cfg.bitmap_pages <= write_data;
          default:          cfg              <= cfg;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            case (mode)
              MODE_FILL: begin
                fill_byte     <= data_byte;
                sweep         <= '0;
                state         <= S_FILL;
                read_data     <= '0;
                byte_written  <= 1'b0;
                write_address <= '0;
                out_valid     <= 1'b1;
              end
              MODE_BITMAP: begin
                read_data     <= '0;
                byte_written  <= pl.placed;
                write_address <= pl.write_address;
                out_valid     <= 1'b1;
              end
              MODE_READ: begin
                rd_ok     <= rd_in_range;
                state     <= S_READ;
                out_valid <= 1'b0;
              end
              default: begin
                read_data     <= '0;
                byte_written  <= 1'b0;
                write_address <= '0;
                out_valid     <= 1'b1;
              end
            endcase
          end else if (out_valid && out_ready) begin
            out_valid <= 1'b0;
          end
        end
        S_FILL: begin
          sweep <= sweep + AW'(1);
          if (sweep == AW'(STORE_SIZE - 1)) begin
            state <= S_IDLE;
          end
          if (out_valid && out_ready) begin
            out_valid <= 1'b0;
          end
        end
        S_READ: begin
          read_data     <= rd_ok ? mem_rdata : '0;
          byte_written  <= 1'b0;
          write_address <= '0;
          out_valid     <= 1'b1;
          state         <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `PBB_ASSERT_SAME(a_no_overwrite, in_valid && in_ready, !out_valid || out_ready, "item accepted over a waiting result")
  `PBB_ASSERT_SAME(a_busy_blocks, state != S_IDLE, !in_ready, "item accepted while busy")
  `PBB_ASSERT_NEXT(a_read_wait, in_valid && in_ready && mode == MODE_READ, state == S_READ && !out_valid, "read did not wait for memory")
  `PBB_ASSERT_SAME(a_clipped_addr, out_valid && !byte_written, write_address == '0, "clipped item carries an address")

endmodule
